FILE: hw/rtl/rc5_pkg.sv
// ----------------------------------------------------------------------------
// RC5 package
// Shared constants, item types, opcodes and rotate helpers for the RC5 block.
// ----------------------------------------------------------------------------
package rc5_pkg;

	localparam int ROUNDS      = 12;
	localparam int KEY_WORDS   = 4;
	localparam int CFG_KEYS    = 4;
	localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
	localparam int MIX_STEPS   = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);

	localparam int WORD_W = 32;
	localparam int ROT_W  = 5;
	localparam int IDX_W  = $clog2(TABLE_WORDS);
	localparam int JW     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int CNT_W  = $clog2(MIX_STEPS + 1);
	localparam int CFG_W  = 3;

	localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
	localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

	localparam logic [CFG_W-1:0] REG_KEY_WORD_0   = 3'd0;
	localparam logic [CFG_W-1:0] REG_KEY_WORD_1   = 3'd1;
	localparam logic [CFG_W-1:0] REG_KEY_WORD_2   = 3'd2;
	localparam logic [CFG_W-1:0] REG_KEY_WORD_3   = 3'd3;
	localparam logic [CFG_W-1:0] REG_DECRYPT_MODE = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [CFG_KEYS-1:0] key_t;

	typedef struct packed {
		word_t block_low;
		word_t block_high;
	} in_item_t;

	typedef struct packed {
		word_t result_low;
		word_t result_high;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_ENC,
		OP_DEC,
		OP_MIX
	} op_t;

	typedef struct packed {
		op_t              op;
		word_t            x;
		word_t            y;
		word_t            k;
		logic [ROT_W-1:0] amt;
	} mix_req_t;

	typedef struct packed {
		logic start;
		logic expand;
		logic decrypt;
	} eng_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_sts_t;

	function automatic word_t rotl(word_t x, logic [ROT_W-1:0] s);
		logic [2*WORD_W-1:0] t;
		t = {x, x} << s;
		return t[2*WORD_W-1:WORD_W];
	endfunction

	function automatic word_t rotr(word_t x, logic [ROT_W-1:0] s);
		logic [2*WORD_W-1:0] t;
		t = {x, x} >> s;
		return t[WORD_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/rc5_block_cipher.sv
// ----------------------------------------------------------------------------
// RC5 block cipher
// RC5-32/12/16 ECB encrypt and decrypt of 64-bit blocks, key and mode set by
// configuration writes.
// ----------------------------------------------------------------------------
// One block passes through the shared add-xor-rotate unit one half-round or
// whitening step per cycle, with one round-key read per step. The block is
// loaded at acceptance; after the last step the engine holds the result until
// it is handed to the output register, and the next block is accepted only
// after that handoff. The first block after reset or after a key word write
// first runs the key expansion through the same unit, alternating S-table and
// key-word mixing steps. Writing the mode alone keeps the expanded key. A
// new block is accepted once the previous one has left the unit, while its
// result may still wait in the output register.
module rc5_block_cipher (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      block_valid,
	output logic                      block_ready,
	input  rc5_pkg::in_item_t         block_data,
	output logic                      result_valid,
	input  logic                      result_ready,
	output rc5_pkg::out_item_t        result_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rc5_pkg::CFG_W-1:0] cfg_index,
	input  rc5_pkg::word_t            cfg_data
);

	rc5_pkg::key_t      key_q;
	logic               decrypt_q;
	logic               sched_ok_q;
	logic               result_valid_q;
	rc5_pkg::out_item_t result_q;

	rc5_pkg::eng_cmd_t  cmd;
	rc5_pkg::eng_sts_t  sts;
	rc5_pkg::out_item_t eng_result;
	logic               ack;
	logic               cfg_wr;
	logic               key_wr;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign key_wr      = cfg_wr && (cfg_index <= rc5_pkg::REG_KEY_WORD_3);
	assign block_ready = !sts.busy;
	assign cmd.start   = block_valid && block_ready;
	assign cmd.expand  = !sched_ok_q;
	assign cmd.decrypt = decrypt_q;
	assign ack         = sts.done && (!result_valid_q || result_ready);

	rc5_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key_words (key_q),
		.blk       (block_data),
		.ack       (ack),
		.sts       (sts),
		.result    (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			decrypt_q  <= 1'b0;
			sched_ok_q <= 1'b0;
		end else begin
			if (cmd.start && !key_wr) begin
				sched_ok_q <= 1'b1;
			end
			if (cfg_wr) begin
				case (cfg_index)
					rc5_pkg::REG_KEY_WORD_0: begin
						key_q[0]   <= cfg_data;
						sched_ok_q <= 1'b0;
					end
					rc5_pkg::REG_KEY_WORD_1: begin
						key_q[1]   <= cfg_data;
						sched_ok_q <= 1'b0;
					end
					rc5_pkg::REG_KEY_WORD_2: begin
						key_q[2]   <= cfg_data;
						sched_ok_q <= 1'b0;
					end
					rc5_pkg::REG_KEY_WORD_3: begin
						key_q[3]   <= cfg_data;
						sched_ok_q <= 1'b0;
					end
					rc5_pkg::REG_DECRYPT_MODE: begin
						decrypt_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// hold the result until taken, load the next one on handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ack) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			result_q <= eng_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

FILE: hw/rtl/rc5_mix_unit.sv
// ----------------------------------------------------------------------------
// RC5 mix unit
// Shared add, subtract, xor and rotate datapath for half-rounds and key mixing.
// ----------------------------------------------------------------------------
module rc5_mix_unit (
	input  rc5_pkg::mix_req_t req,
	output rc5_pkg::word_t    res
);

	always_comb begin
		case (req.op)
			rc5_pkg::OP_ENC: res = rc5_pkg::rotl(req.x ^ req.y, req.y[rc5_pkg::ROT_W-1:0]) + req.k;
			rc5_pkg::OP_DEC: res = rc5_pkg::rotr(req.x - req.k, req.y[rc5_pkg::ROT_W-1:0]) ^ req.y;
			rc5_pkg::OP_MIX: res = rc5_pkg::rotl(req.x + req.y + req.k, req.amt);
			default:         res = req.x;
		endcase
	end

endmodule

FILE: hw/rtl/rc5_engine.sv
// ----------------------------------------------------------------------------
// RC5 engine
// Sequencer with round-key store: key expansion when requested, then one half-round or whitening step a cycle.
// ----------------------------------------------------------------------------
module rc5_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  rc5_pkg::eng_cmd_t   cmd,
	input  rc5_pkg::key_t       key_words,
	input  rc5_pkg::in_item_t   blk,
	input  logic                ack,
	output rc5_pkg::eng_sts_t   sts,
	output rc5_pkg::out_item_t  result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_S,
		ST_MIX_L,
		ST_CRYPT,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [rc5_pkg::IDX_W-1:0]       i_q;
	logic [rc5_pkg::JW-1:0]          j_q;
	logic [rc5_pkg::CNT_W-1:0]       cnt_q;
	logic [rc5_pkg::IDX_W-1:0]       step_q;
	logic                            dec_q;

	rc5_pkg::word_t                  a_q;
	rc5_pkg::word_t                  b_q;
	rc5_pkg::word_t                  ma_q;
	rc5_pkg::word_t                  mb_q;
	rc5_pkg::word_t                  init_q;
	rc5_pkg::word_t                  sk_q [rc5_pkg::TABLE_WORDS];
	rc5_pkg::word_t                  lw_q [rc5_pkg::KEY_WORDS];

	rc5_pkg::mix_req_t               req;
	rc5_pkg::word_t                  unit_res;
	logic [rc5_pkg::IDX_W-1:0]       key_idx;
	logic                            tgt_a;
	logic                            first_pass;
	logic                            last_mix;
	logic [rc5_pkg::IDX_W-1:0]       i_nxt;
	logic [rc5_pkg::JW-1:0]          j_nxt;

	rc5_mix_unit u_mix (
		.req (req),
		.res (unit_res)
	);

	always_comb begin
		if (!dec_q) begin
			key_idx = step_q;
		end else if (step_q < rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS - 2)) begin
			key_idx = rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS - 1) - step_q;
		end else begin
			key_idx = step_q - rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS - 2);
		end
		tgt_a      = !key_idx[0];
		first_pass = cnt_q < rc5_pkg::CNT_W'(rc5_pkg::TABLE_WORDS);
		last_mix   = cnt_q == rc5_pkg::CNT_W'(rc5_pkg::MIX_STEPS - 1);
		i_nxt      = (i_q == rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS - 1)) ? '0 : i_q + 1'b1;
		j_nxt      = (j_q == rc5_pkg::JW'(rc5_pkg::KEY_WORDS - 1)) ? '0 : j_q + 1'b1;
	end

	always_comb begin
		req.op  = rc5_pkg::OP_MIX;
		req.x   = first_pass ? init_q : sk_q[i_q];
		req.y   = ma_q;
		req.k   = mb_q;
		req.amt = rc5_pkg::ROT_W'(3);
		case (state_q)
			ST_MIX_L: begin
				req.x   = lw_q[j_q];
				req.amt = ma_q[rc5_pkg::ROT_W-1:0] + mb_q[rc5_pkg::ROT_W-1:0];
			end
			ST_CRYPT: begin
				req.op = dec_q ? rc5_pkg::OP_DEC : rc5_pkg::OP_ENC;
				req.x  = tgt_a ? a_q : b_q;
				req.y  = (key_idx < rc5_pkg::IDX_W'(2)) ? '0 : (tgt_a ? b_q : a_q);
				req.k  = sk_q[key_idx];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			step_q  <= '0;
			dec_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						dec_q  <= cmd.decrypt;
						i_q    <= '0;
						j_q    <= '0;
						cnt_q  <= '0;
						step_q <= '0;
						state_q <= cmd.expand ? ST_MIX_S : ST_CRYPT;
					end
				end
				ST_MIX_S: begin
					state_q <= ST_MIX_L;
				end
				ST_MIX_L: begin
					i_q   <= i_nxt;
					j_q   <= j_nxt;
					cnt_q <= cnt_q + 1'b1;
					if (last_mix) begin
						state_q <= ST_CRYPT;
					end else begin
						state_q <= ST_MIX_S;
					end
				end
				ST_CRYPT: begin
					step_q <= step_q + 1'b1;
					if (step_q == rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					a_q    <= blk.block_low;
					b_q    <= blk.block_high;
					ma_q   <= '0;
					mb_q   <= '0;
					init_q <= rc5_pkg::MAGIC_P;
					if (cmd.expand) begin
						for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
							if (k < rc5_pkg::CFG_KEYS) begin
								lw_q[k] <= key_words[k % rc5_pkg::CFG_KEYS];
							end else begin
								lw_q[k] <= '0;
							end
						end
					end
				end
			end
			ST_MIX_S: begin
				sk_q[i_q] <= unit_res;
				ma_q      <= unit_res;
				init_q    <= init_q + rc5_pkg::MAGIC_Q;
			end
			ST_MIX_L: begin
				lw_q[j_q] <= unit_res;
				mb_q      <= unit_res;
			end
			ST_CRYPT: begin
				if (tgt_a) begin
					a_q <= unit_res;
				end else begin
					b_q <= unit_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.busy           = state_q != ST_IDLE;
	assign sts.done           = state_q == ST_DONE;
	assign result.result_low  = a_q;
	assign result.result_high = b_q;

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !ack) |=> state_q == ST_DONE)
		else $error("result dropped before handoff");

	a_mix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_S || state_q == ST_MIX_L) |->
			(cnt_q < rc5_pkg::CNT_W'(rc5_pkg::MIX_STEPS) &&
			 i_q < rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS)))
		else $error("key mixing counter out of range");

	a_mix_to_crypt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_L && last_mix) |=> (state_q == ST_CRYPT && step_q == '0))
		else $error("block processing did not follow key expansion");

	a_crypt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CRYPT |-> step_q < rc5_pkg::IDX_W'(rc5_pkg::TABLE_WORDS))
		else $error("round step out of range");

endmodule

FILE: dv/tb_rc5_block_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC5 block cipher testbench
// Drives 64-bit blocks through rc5_block_cipher under several keys and modes.
// A built-in RC5-32/12/16 model works out each output block, and the checker
// compares every output item against it. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module tb_rc5_block_cipher;

	localparam int SETTLE_CYCLES = 200;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        block_valid = 1'b0;
	logic                        block_ready;
	rc5_pkg::in_item_t           block_data = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	rc5_pkg::out_item_t          result_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [rc5_pkg::CFG_W-1:0]   cfg_index = '0;
	rc5_pkg::word_t              cfg_data = '0;

	rc5_pkg::word_t              user_key [rc5_pkg::CFG_KEYS];
	logic                        decrypt_on;
	rc5_pkg::word_t              round_key [rc5_pkg::TABLE_WORDS];
	bit                          schedule_built;
	rc5_pkg::out_item_t          pending_blocks [$];
	int                          error_count = 0;
	int                          send_idle_pct = 0;
	int                          recv_stall_pct = 0;

	rc5_block_cipher uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.block_valid  (block_valid),
		.block_ready  (block_ready),
		.block_data   (block_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic rc5_pkg::word_t rol32(rc5_pkg::word_t x, int unsigned n);
		int unsigned s;
		s = n & 31;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic rc5_pkg::word_t ror32(rc5_pkg::word_t x, int unsigned n);
		int unsigned s;
		s = n & 31;
		if (s == 0)
			return x;
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic void expand_schedule();
		rc5_pkg::word_t mix [rc5_pkg::KEY_WORDS];
		rc5_pkg::word_t a;
		rc5_pkg::word_t b;
		int             i;
		int             j;
		for (int k = 0; k < rc5_pkg::KEY_WORDS; k++)
			mix[k] = (k < rc5_pkg::CFG_KEYS) ? user_key[k] : '0;
		round_key[0] = rc5_pkg::MAGIC_P;
		for (int k = 1; k < rc5_pkg::TABLE_WORDS; k++)
			round_key[k] = round_key[k-1] + rc5_pkg::MAGIC_Q;
		a = '0;
		b = '0;
		i = 0;
		j = 0;
		for (int k = 0; k < rc5_pkg::MIX_STEPS; k++) begin
			round_key[i] = rol32(round_key[i] + a + b, 3);
			a = round_key[i];
			mix[j] = rol32(mix[j] + a + b, a + b);
			b = mix[j];
			i = (i + 1) % rc5_pkg::TABLE_WORDS;
			j = (j + 1) % rc5_pkg::KEY_WORDS;
		end
		schedule_built = 1'b1;
	endfunction

	function automatic rc5_pkg::out_item_t rc5_crypt(rc5_pkg::in_item_t blk);
		rc5_pkg::word_t     a;
		rc5_pkg::word_t     b;
		rc5_pkg::out_item_t res;
		if (!schedule_built)
			expand_schedule();
		a = blk.block_low;
		b = blk.block_high;
		if (!decrypt_on) begin
			a = a + round_key[0];
			b = b + round_key[1];
			for (int rnd = 1; rnd <= rc5_pkg::ROUNDS; rnd++) begin
				a = rol32(a ^ b, b) + round_key[2*rnd];
				b = rol32(b ^ a, a) + round_key[2*rnd+1];
			end
		end else begin
			for (int rnd = rc5_pkg::ROUNDS; rnd >= 1; rnd--) begin
				b = ror32(b - round_key[2*rnd+1], a) ^ a;
				a = ror32(a - round_key[2*rnd], b) ^ b;
			end
			a = a - round_key[0];
			b = b - round_key[1];
		end
		res.result_low = a;
		res.result_high = b;
		return res;
	endfunction

	function automatic rc5_pkg::word_t random_word();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return rc5_pkg::word_t'(1) << $urandom_range(0, 31);
			3: return ~(rc5_pkg::word_t'(1) << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin : check_output
		rc5_pkg::out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected item: expected none actual %h_%h", $time,
					result_data.result_low, result_data.result_high);
				error_count++;
			end else begin
				want = pending_blocks.pop_front();
				if (result_data.result_low !== want.result_low) begin
					$display("%0t: result_low mismatch: expected %h actual %h", $time,
						want.result_low, result_data.result_low);
					error_count++;
				end
				if (result_data.result_high !== want.result_high) begin
					$display("%0t: result_high mismatch: expected %h actual %h", $time,
						want.result_high, result_data.result_high);
					error_count++;
				end
			end
		end
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic send_block(rc5_pkg::in_item_t blk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			block_valid <= 1'b0;
			@(posedge clk);
		end
		block_valid <= 1'b1;
		block_data <= blk;
		pending_blocks.push_back(rc5_crypt(blk));
		do @(posedge clk); while (!block_ready);
	endtask

	task automatic wait_idle();
		block_valid <= 1'b0;
		do @(posedge clk); while (pending_blocks.size() != 0);
	endtask

	// leave cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [rc5_pkg::CFG_W-1:0] idx, rc5_pkg::word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rc5_pkg::REG_KEY_WORD_0, rc5_pkg::REG_KEY_WORD_1,
			rc5_pkg::REG_KEY_WORD_2, rc5_pkg::REG_KEY_WORD_3: begin
				user_key[idx] = value;
				schedule_built = 1'b0;
			end
			rc5_pkg::REG_DECRYPT_MODE: decrypt_on = value[0];
			default: ;
		endcase
	endtask

	task automatic test_reset_key();
		send_block('{32'h0000_0000, 32'h0000_0000});
		send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_block('{32'h0000_0000, 32'hFFFF_FFFF});
		send_block('{32'h8000_0000, 32'h0000_0001});
		send_block('{32'hAAAA_AAAA, 32'h5555_5555});
		wait_idle();
	endtask

	task automatic test_key_extremes();
		rc5_pkg::out_item_t ct0;
		rc5_pkg::out_item_t ct1;
		write_reg(rc5_pkg::REG_KEY_WORD_0, '1);
		write_reg(rc5_pkg::REG_KEY_WORD_1, '1);
		write_reg(rc5_pkg::REG_KEY_WORD_2, '1);
		write_reg(rc5_pkg::REG_KEY_WORD_3, '1);
		write_reg(rc5_pkg::REG_DECRYPT_MODE, 32'h0000_0000);
		cfg_valid <= 1'b0;
		send_block('{32'h0123_4567, 32'h89AB_CDEF});
		ct0 = pending_blocks[$];
		send_block('{32'hFFFF_FFFF, 32'h0000_0000});
		ct1 = pending_blocks[$];
		wait_idle();
		// mode change alone keeps the expanded key
		write_reg(rc5_pkg::REG_DECRYPT_MODE, 32'h8000_0001);
		cfg_valid <= 1'b0;
		send_block('{ct0.result_low, ct0.result_high});
		send_block('{ct1.result_low, ct1.result_high});
		wait_idle();
		write_reg(rc5_pkg::REG_DECRYPT_MODE, 32'hFFFF_FFFE);
		cfg_valid <= 1'b0;
		send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		wait_idle();
		write_reg(3'd5, $urandom);
		write_reg(3'd6, $urandom);
		write_reg(3'd7, '1);
		cfg_valid <= 1'b0;
		send_block('{32'h0000_0000, 32'h0000_0000});
		wait_idle();
	endtask

	task automatic test_round_trip();
		rc5_pkg::out_item_t ct [4];
		for (int k = 0; k < rc5_pkg::CFG_KEYS; k++)
			write_reg(k[rc5_pkg::CFG_W-1:0], random_word());
		write_reg(rc5_pkg::REG_DECRYPT_MODE, 32'h0);
		cfg_valid <= 1'b0;
		for (int n = 0; n < 4; n++) begin
			send_block('{random_word(), random_word()});
			ct[n] = pending_blocks[$];
		end
		wait_idle();
		write_reg(rc5_pkg::REG_DECRYPT_MODE, 32'h1);
		cfg_valid <= 1'b0;
		for (int n = 0; n < 4; n++)
			send_block('{ct[n].result_low, ct[n].result_high});
		wait_idle();
	endtask

	task automatic test_random(int idle_pct, int stall_pct, int settings, int per_setting);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < settings; s++) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: ;
				1: write_reg(rc5_pkg::CFG_W'($urandom_range(0, rc5_pkg::CFG_KEYS - 1)),
					random_word());
				default: begin
					for (int k = 0; k < rc5_pkg::CFG_KEYS; k++)
						write_reg(k[rc5_pkg::CFG_W-1:0], random_word());
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(rc5_pkg::CFG_W'($urandom_range(rc5_pkg::REG_DECRYPT_MODE + 1, 7)),
					$urandom);
			write_reg(rc5_pkg::REG_DECRYPT_MODE, $urandom);
			cfg_valid <= 1'b0;
			for (int n = 0; n < per_setting; n++) begin
				if ($urandom_range(0, 49) == 0)
					wait_idle();
				send_block('{random_word(), random_word()});
			end
		end
		wait_idle();
	endtask

	initial begin
		for (int k = 0; k < rc5_pkg::CFG_KEYS; k++)
			user_key[k] = '0;
		decrypt_on = 1'b0;
		schedule_built = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_key_extremes();
		test_round_trip();
		test_random(0, 0, 8, 55);
		test_random(56, 0, 8, 55);
		test_random(0, 56, 8, 55);
		test_random(30, 30, 8, 55);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
